>>> rtl/qnhd_pkg.sv
`default_nettype none
package qnhd_pkg;

   // Field widths
   localparam int ANGLE_BITS = 16;
   localparam int VALUE_BITS = 32;
   localparam int TRIG_BITS = 32;
   localparam int XB = 31;

   // Configuration
   localparam int GRAVITY_BITS = 31;
   localparam logic [GRAVITY_BITS-1:0] GRAVITY_RESET = 31'd642908;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [0:0] REG_GRAVITY = 1'b0;

   // Quarter-wave sine polynomial, Q2.30
   localparam logic [XB-1:0] Q30_ONE = 31'd1073741824;
   localparam logic [31:0] POLY_C11 = 32'd3864;
   typedef logic [31:0] coef_arr_type [5];
   localparam coef_arr_type POLY_COEF = '{32'd172272, 32'd5026995, 32'd85569306,
                                          32'd693598668, 32'd1686629713};

   localparam int SINE_LATENCY = 8;
   localparam int PIPE_LATENCY = SINE_LATENCY + 4;

endpackage
`default_nettype wire

>>> rtl/qnhd_req_if.sv
`default_nettype none
interface qnhd_req_if;
   logic valid;
   logic ready;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] vel_x;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] vel_y;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] vel_z;
   logic signed [qnhd_pkg::ANGLE_BITS-1:0] heading;
   logic signed [qnhd_pkg::ANGLE_BITS-1:0] roll;
   logic signed [qnhd_pkg::ANGLE_BITS-1:0] pitch;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] yaw_rate_cmd;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] thrust;

   modport source (output valid, vel_x, vel_y, vel_z, heading, roll, pitch,
                   yaw_rate_cmd, thrust, input ready);
   modport sink (input valid, vel_x, vel_y, vel_z, heading, roll, pitch,
                 yaw_rate_cmd, thrust, output ready);
endinterface
`default_nettype wire

>>> rtl/qnhd_rsp_if.sv
`default_nettype none
interface qnhd_rsp_if;
   logic valid;
   logic ready;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] pos_x_rate;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] pos_y_rate;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] pos_z_rate;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] accel_x;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] accel_y;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] accel_z;
   logic signed [qnhd_pkg::VALUE_BITS-1:0] heading_rate;

   modport source (output valid, pos_x_rate, pos_y_rate, pos_z_rate, accel_x,
                    accel_y, accel_z, heading_rate, input ready);
   modport sink (input valid, pos_x_rate, pos_y_rate, pos_z_rate, accel_x,
                  accel_y, accel_z, heading_rate, output ready);
endinterface
`default_nettype wire

>>> rtl/qnhd_sine.sv
`default_nettype none
module qnhd_sine (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic [qnhd_pkg::ANGLE_BITS-1:0]        angle,
   output logic signed [qnhd_pkg::TRIG_BITS-1:0]       value
);
   localparam int AB = qnhd_pkg::ANGLE_BITS;
   localparam int XB = qnhd_pkg::XB;

   logic [1:0]    quad;
   logic [XB-1:0] x_raw;
   logic [XB-1:0] x_in;
   logic [XB-1:0] x1_ff;
   logic          n1_ff;
   logic [2*XB-1:0] sq;

   logic [XB-1:0] xv_ff  [0:5];
   logic [XB-1:0] x2q_ff [0:4];
   logic          neg_ff [0:5];
   logic [31:0]   p_ff   [0:4];

   logic [62:0]   fprod;
   logic [32:0]   fmag;
   logic [XB-1:0] fclamp;
   logic signed [qnhd_pkg::TRIG_BITS-1:0] value_in;
   logic signed [qnhd_pkg::TRIG_BITS-1:0] value_ff;

   // Fold angle into first quadrant
   always_comb begin
      quad  = angle[AB-1:AB-2];
      x_raw = XB'(angle[AB-3:0]) << (32 - AB);
      x_in  = quad[0] ? (qnhd_pkg::Q30_ONE - x_raw) : x_raw;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= x_in;
         n1_ff <= quad[1];
      end
   end

   // Square the folded angle
   assign sq = x1_ff * x1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xv_ff[0]  <= x1_ff;
         x2q_ff[0] <= sq[XB+29:30];
         neg_ff[0] <= n1_ff;
      end
   end

   // Horner steps, one coefficient per stage
   for (genvar k = 0; k < 5; k++) begin : g_poly
      logic [31:0] prev;
      logic [62:0] prod;
      if (k == 0) begin : g_first
         assign prev = qnhd_pkg::POLY_C11;
      end else begin : g_next
         assign prev = p_ff[k-1];
      end
      assign prod = prev * x2q_ff[k];
      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[k]     <= qnhd_pkg::POLY_COEF[k] - prod[61:30];
            xv_ff[k+1]  <= xv_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
      // Carry the squared angle to the next step
      if (k < 4) begin : g_x2
         always_ff @(posedge clock) begin
            if (en) begin
               x2q_ff[k+1] <= x2q_ff[k];
            end
         end
      end
   end

   // Final multiply, clamp to one, apply sign
   always_comb begin
      fprod    = p_ff[4] * xv_ff[5];
      fmag     = fprod[62:30];
      fclamp   = (fmag > 33'(qnhd_pkg::Q30_ONE)) ? qnhd_pkg::Q30_ONE : fmag[XB-1:0];
      value_in = neg_ff[5] ? -$signed({1'b0, fclamp}) : $signed({1'b0, fclamp});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;
endmodule
`default_nettype wire

>>> rtl/quadrotor_near_hover_derivative.sv
`default_nettype none
// Near-hover quadrotor derivative. Takes one state/control beat per cycle on
// req_chan and returns the 7-element time derivative on rsp_chan. It passes
// through pipelined quarter-wave sine polynomials (six units, sine and cosine
// of heading, roll and pitch), then trig products, sums, thrust product and
// saturation, one stage each. Throughput is one beat per cycle; the whole
// pipeline holds when the output register is full and not taken.
// Gravity (unsigned Q15.16, reset 9.81) is written where APB paddr[2] is 0.
module quadrotor_near_hover_derivative (
   input  wire logic                                clock,
   input  wire logic                                reset,
   qnhd_req_if.sink                                 req_chan,
   qnhd_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [qnhd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [qnhd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [qnhd_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                     csr_pready
);
   localparam int VB = qnhd_pkg::VALUE_BITS;
   localparam int AB = qnhd_pkg::ANGLE_BITS;
   localparam int TB = qnhd_pkg::TRIG_BITS;
   localparam int NL = qnhd_pkg::PIPE_LATENCY;
   localparam int SL = qnhd_pkg::SINE_LATENCY;

   typedef struct packed {
      logic signed [VB-1:0] vel_x;
      logic signed [VB-1:0] vel_y;
      logic signed [VB-1:0] vel_z;
      logic signed [VB-1:0] yaw_rate_cmd;
      logic signed [VB-1:0] thrust;
   } pass_type;

   logic [qnhd_pkg::GRAVITY_BITS-1:0] gravity_ff;
   logic     adv;
   logic     v_ff    [0:NL-1];
   pass_type pass_ff [0:NL-1];

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = qnhd_pkg::CSR_DATA_BITS'(gravity_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= qnhd_pkg::GRAVITY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == qnhd_pkg::REG_GRAVITY) begin
         gravity_ff <= csr_pwdata[qnhd_pkg::GRAVITY_BITS-1:0];
      end
   end

   // Advance whole pipeline unless the output beat is stuck
   assign adv            = !v_ff[NL-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NL; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_chan.valid;
         for (int i = 1; i < NL; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pass_ff[0] <= '{vel_x: req_chan.vel_x, vel_y: req_chan.vel_y,
                         vel_z: req_chan.vel_z, yaw_rate_cmd: req_chan.yaw_rate_cmd,
                         thrust: req_chan.thrust};
         for (int i = 1; i < NL; i++) begin
            pass_ff[i] <= pass_ff[i-1];
         end
      end
   end

   // Sine and cosine units
   localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
   logic signed [TB-1:0] s_psi, c_psi, s_ph, c_ph, s_th, c_th;

   qnhd_sine u_s_psi (.clock(clock), .en(adv), .angle(req_chan.heading), .value(s_psi));
   qnhd_sine u_c_psi (.clock(clock), .en(adv), .angle(req_chan.heading + QUARTER),
                      .value(c_psi));
   qnhd_sine u_s_ph  (.clock(clock), .en(adv), .angle(req_chan.roll), .value(s_ph));
   qnhd_sine u_c_ph  (.clock(clock), .en(adv), .angle(req_chan.roll + QUARTER),
                      .value(c_ph));
   qnhd_sine u_s_th  (.clock(clock), .en(adv), .angle(req_chan.pitch), .value(s_th));
   qnhd_sine u_c_th  (.clock(clock), .en(adv), .angle(req_chan.pitch + QUARTER),
                      .value(c_th));

   // Q30 product with magnitude truncation
   function automatic logic signed [TB-1:0] trig_mul(input logic signed [TB-1:0] a,
                                                      input logic signed [TB-1:0] b);
      logic [TB-1:0]   ma;
      logic [TB-1:0]   mb;
      logic [2*TB-1:0] pr;
      logic [TB-1:0]   m;
      ma = a[TB-1] ? -a : a;
      mb = b[TB-1] ? -b : b;
      pr = ma * mb;
      m  = pr[TB+29:30];
      return (a[TB-1] != b[TB-1]) ? -$signed(m) : $signed(m);
   endfunction

   // Trig products
   logic signed [TB-1:0] pr_ff [0:4];

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff[0] <= trig_mul(s_th, c_psi);
         pr_ff[1] <= trig_mul(s_ph, s_psi);
         pr_ff[2] <= trig_mul(s_ph, c_psi);
         pr_ff[3] <= trig_mul(s_th, s_psi);
         pr_ff[4] <= trig_mul(c_ph, c_th);
      end
   end

   // Direction factors
   logic signed [TB:0] f_ff [0:2];

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff[0] <= (TB+1)'(pr_ff[0]) - (TB+1)'(pr_ff[1]);
         f_ff[1] <= (TB+1)'(pr_ff[2]) + (TB+1)'(pr_ff[3]);
         f_ff[2] <= (TB+1)'(pr_ff[4]);
      end
   end

   // Thrust magnitude products
   localparam int MQB = VB + TB + 1 - 30;
   logic [VB-1:0]       t_mag;
   logic                t_neg;
   logic [MQB-1:0]      mq_ff  [0:2];
   logic                neg_ff [0:2];

   always_comb begin
      t_neg = pass_ff[SL+1].thrust[VB-1];
      t_mag = t_neg ? -pass_ff[SL+1].thrust : pass_ff[SL+1].thrust;
   end

   for (genvar k = 0; k < 3; k++) begin : g_thr
      logic [TB:0]      f_mag;
      logic [VB+TB:0]   prod;
      assign f_mag = f_ff[k][TB] ? -f_ff[k] : f_ff[k];
      assign prod  = t_mag * f_mag;
      always_ff @(posedge clock) begin
         if (adv) begin
            mq_ff[k]  <= prod[VB+TB:30];
            neg_ff[k] <= t_neg != f_ff[k][TB];
         end
      end
   end

   // Sign, gravity and saturation into the output register
   localparam int SB = MQB + 2;
   localparam logic signed [SB-1:0] SAT_HI = SB'((64'sd1 <<< (VB - 1)) - 1);
   localparam logic signed [SB-1:0] SAT_LO = -SAT_HI - SB'(1);
   logic signed [SB-1:0] acc [0:2];
   logic signed [VB-1:0] acc_ff [0:2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc[k] = neg_ff[k] ? -$signed(SB'(mq_ff[k])) : $signed(SB'(mq_ff[k]));
      end
      acc[2] = acc[2] - $signed(SB'(gravity_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            if (acc[k] > SAT_HI) begin
               acc_ff[k] <= SAT_HI[VB-1:0];
            end else if (acc[k] < SAT_LO) begin
               acc_ff[k] <= SAT_LO[VB-1:0];
            end else begin
               acc_ff[k] <= acc[k][VB-1:0];
            end
         end
      end
   end

   // Drive result beat
   assign rsp_chan.valid        = v_ff[NL-1];
   assign rsp_chan.pos_x_rate   = pass_ff[NL-1].vel_x;
   assign rsp_chan.pos_y_rate   = pass_ff[NL-1].vel_y;
   assign rsp_chan.pos_z_rate   = pass_ff[NL-1].vel_z;
   assign rsp_chan.heading_rate = pass_ff[NL-1].yaw_rate_cmd;
   assign rsp_chan.accel_x      = acc_ff[0];
   assign rsp_chan.accel_y      = acc_ff[1];
   assign rsp_chan.accel_z      = acc_ff[2];
endmodule
`default_nettype wire

>>> dv/qnhd_deriv_checker.sv
`timescale 1ns / 1ps
module qnhd_deriv_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   qnhd_req_if.sink                            req_mon,
   qnhd_rsp_if.sink                            rsp_mon,
   input  wire logic [qnhd_pkg::GRAVITY_BITS-1:0] gravity_model,
   output int                                  fail_count,
   output int                                  pending_count
);
   typedef struct packed {
      logic signed [qnhd_pkg::VALUE_BITS-1:0] pos_x_rate;
      logic signed [qnhd_pkg::VALUE_BITS-1:0] pos_y_rate;
      logic signed [qnhd_pkg::VALUE_BITS-1:0] pos_z_rate;
      logic signed [qnhd_pkg::VALUE_BITS-1:0] accel_x;
      logic signed [qnhd_pkg::VALUE_BITS-1:0] accel_y;
      logic signed [qnhd_pkg::VALUE_BITS-1:0] accel_z;
      logic signed [qnhd_pkg::VALUE_BITS-1:0] heading_rate;
   } deriv_type;

   deriv_type deriv_queue[$];

   // quarter-wave sine polynomial, x in Q2.30
   function automatic longint quarter_wave(longint unsigned x);
      longint unsigned x2, p;
      x2 = (x * x) >> 30;
      p = qnhd_pkg::POLY_C11;
      for (int k = 0; k < 5; k++) p = qnhd_pkg::POLY_COEF[k] - ((p * x2) >> 30);
      p = (p * x) >> 30;
      if (p > qnhd_pkg::Q30_ONE) p = qnhd_pkg::Q30_ONE;
      return longint'(p);
   endfunction

   function automatic longint angle_sine(logic [qnhd_pkg::ANGLE_BITS-1:0] a);
      logic [1:0] quad;
      longint unsigned x;
      quad = a[qnhd_pkg::ANGLE_BITS-1 -: 2];
      x = longint'(a[qnhd_pkg::ANGLE_BITS-3:0]) << (32 - qnhd_pkg::ANGLE_BITS);
      if (quad[0]) x = qnhd_pkg::Q30_ONE - x;
      return quad[1] ? -quarter_wave(x) : quarter_wave(x);
   endfunction

   function automatic longint angle_cosine(logic [qnhd_pkg::ANGLE_BITS-1:0] a);
      logic [qnhd_pkg::ANGLE_BITS-1:0] b;
      b = a + qnhd_pkg::ANGLE_BITS'(1 << (qnhd_pkg::ANGLE_BITS - 2));
      return angle_sine(b);
   endfunction

   // exact product shifted right by 30, truncated toward zero
   function automatic longint q30_product(longint a, longint b);
      logic signed [127:0] p;
      logic [127:0] m;
      p = 128'(signed'(a)) * 128'(signed'(b));
      m = p[127] ? -p : p;
      m = m >> 30;
      return p[127] ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [qnhd_pkg::VALUE_BITS-1:0] clamp_value(longint v);
      if (v > 64'sh7fffffff) return 32'h7fffffff;
      if (v < -64'sh80000000) return 32'h80000000;
      return v[qnhd_pkg::VALUE_BITS-1:0];
   endfunction

   function automatic deriv_type predict_derivative(
         logic [qnhd_pkg::GRAVITY_BITS-1:0] grav);
      deriv_type d;
      longint t, sps, cps, sph, cph, sth, cth, fx, fy, fz;
      t = longint'(req_mon.thrust);
      sps = angle_sine(req_mon.heading);
      cps = angle_cosine(req_mon.heading);
      sph = angle_sine(req_mon.roll);
      cph = angle_cosine(req_mon.roll);
      sth = angle_sine(req_mon.pitch);
      cth = angle_cosine(req_mon.pitch);
      fx = q30_product(sth, cps) - q30_product(sph, sps);
      fy = q30_product(sph, cps) + q30_product(sth, sps);
      fz = q30_product(cph, cth);
      d.pos_x_rate = req_mon.vel_x;
      d.pos_y_rate = req_mon.vel_y;
      d.pos_z_rate = req_mon.vel_z;
      d.accel_x = clamp_value(q30_product(t, fx));
      d.accel_y = clamp_value(q30_product(t, fy));
      d.accel_z = clamp_value(q30_product(t, fz) - longint'(grav));
      d.heading_rate = req_mon.yaw_rate_cmd;
      return d;
   endfunction

   assign pending_count = deriv_queue.size();

   // predict on each input beat, compare on each result beat
   always @(posedge clock) begin
      deriv_type exp_d, act_d;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            deriv_queue.push_back(predict_derivative(gravity_model));
         if (rsp_mon.valid && rsp_mon.ready) begin
            act_d = '{rsp_mon.pos_x_rate, rsp_mon.pos_y_rate, rsp_mon.pos_z_rate,
                      rsp_mon.accel_x, rsp_mon.accel_y, rsp_mon.accel_z,
                      rsp_mon.heading_rate};
            if (deriv_queue.size() == 0) begin
               $display("%0t: unexpected result beat, actual %h", $time, act_d);
               fail_count <= fail_count + 1;
            end else begin
               exp_d = deriv_queue.pop_front();
               if (exp_d !== act_d) begin
                  $display("%0t: mismatch pos %h %h %h acc %h %h %h hr %h",
                           $time, exp_d.pos_x_rate, exp_d.pos_y_rate,
                           exp_d.pos_z_rate, exp_d.accel_x, exp_d.accel_y,
                           exp_d.accel_z, exp_d.heading_rate);
                  $display("%0t:   actual pos %h %h %h acc %h %h %h hr %h",
                           $time, act_d.pos_x_rate, act_d.pos_y_rate,
                           act_d.pos_z_rate, act_d.accel_x, act_d.accel_y,
                           act_d.accel_z, act_d.heading_rate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> dv/tb_quadrotor_near_hover_derivative.sv
`timescale 1ns / 1ps
module tb_quadrotor_near_hover_derivative;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [qnhd_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [qnhd_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [qnhd_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;
   logic [qnhd_pkg::GRAVITY_BITS-1:0] gravity_model = qnhd_pkg::GRAVITY_RESET;
   int fail_count, pending_count, cycle_count = 0;
   bit long_hold = 0;

   qnhd_req_if req_chan ();
   qnhd_rsp_if rsp_chan ();

   quadrotor_near_hover_derivative dut (
      .clock, .reset, .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   qnhd_deriv_checker checker_i (
      .clock, .reset, .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink),
      .gravity_model, .fail_count, .pending_count
   );

   always #2 clock = ~clock;

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stall pattern, with a long hold-off when requested
   initial begin
      rsp_chan.ready = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_chan.ready <= 0;
            repeat (60) @(negedge clock);
            long_hold = 0;
         end
         case ($urandom_range(0, 3))
            0: rsp_chan.ready <= 0;
            1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_chan.ready <= 1;
         endcase
      end
   end

   task automatic write_gravity(logic [qnhd_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1;
      csr_paddr <= qnhd_pkg::CSR_ADDR_BITS'(4 * qnhd_pkg::REG_GRAVITY);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      gravity_model <= value[qnhd_pkg::GRAVITY_BITS-1:0];
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic drain_pipeline();
      while (pending_count != 0) @(negedge clock);
      repeat (qnhd_pkg::PIPE_LATENCY + 4) @(negedge clock);
   endtask

   // drive one beat and hold it until accepted
   task automatic send_state(logic [31:0] vx, vy, vz, logic [15:0] hd, rl, pt,
                             logic [31:0] wr, th);
      req_chan.valid <= 1;
      req_chan.vel_x <= vx; req_chan.vel_y <= vy; req_chan.vel_z <= vz;
      req_chan.heading <= hd; req_chan.roll <= rl; req_chan.pitch <= pt;
      req_chan.yaw_rate_cmd <= wr; req_chan.thrust <= th;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      req_chan.valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 4))
         0: return 16'(16'h4000 * $urandom_range(0, 3));
         1: return 16'($urandom_range(0, 8) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_thrust();
      case ($urandom_range(0, 4))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($urandom_range(0, 2000000));
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         repeat ($urandom_range(1, 20)) begin
            if (sent < count) begin
               send_state($urandom, $urandom, $urandom, rand_angle(), rand_angle(),
                          rand_angle(), $urandom, rand_thrust());
               sent++;
            end
         end
         if ($urandom_range(0, 2) == 0) idle_gap();
      end
      req_chan.valid <= 0;
   endtask

   initial begin
      logic [31:0] ext [4];
      logic [15:0] ang [6];
      ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
      ang = '{16'h0, 16'h4000, 16'h8000, 16'hc000, 16'h7fff, 16'hffff};
      req_chan.valid = 0;
      req_chan.vel_x = '0; req_chan.vel_y = '0; req_chan.vel_z = '0;
      req_chan.heading = '0; req_chan.roll = '0; req_chan.pitch = '0;
      req_chan.yaw_rate_cmd = '0; req_chan.thrust = '0;
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: extremes of values and cardinal angles at reset gravity
      for (int i = 0; i < 6; i++)
         send_state(ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4], ang[i],
                    ang[(i + 2) % 6], ang[(i + 4) % 6], ext[(i + 3) % 4],
                    ext[i % 4]);
      for (int i = 0; i < 6; i++)
         send_state('0, '0, '0, '0, ang[i], ang[5 - i], '0, 32'h00100000);
      send_state('0, '0, '0, '0, '0, '0, '0, 32'h0009cf5c);
      send_state('0, '0, '0, 16'h2000, 16'h2000, 16'h2000, '0, 32'h7fffffff);
      req_chan.valid <= 0;
      drain_pipeline();

      // random with the receiver holding off so the pipeline backs up
      long_hold = 1;
      random_phase(RANDOM_ITEMS / 4);
      drain_pipeline();

      // gravity extremes and an ordinary value
      write_gravity(32'h0);
      random_phase(RANDOM_ITEMS / 4);
      drain_pipeline();
      write_gravity(32'h7fffffff);
      send_state('0, '0, '0, '0, '0, '0, '0, 32'h80000000);
      random_phase(RANDOM_ITEMS / 4);
      drain_pipeline();
      write_gravity(32'h80000000 | $urandom);
      random_phase(RANDOM_ITEMS / 4);
      drain_pipeline();

      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
